/* sv/mird_pkg.sv */
// shared types and constants for the manchester ir frame decoder
package mird_pkg;

    localparam logic [3:0] FRAME_BITS = 4'd14;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CFG_HALF_BIT_TIME    = 3'd0,
        CFG_FULL_BIT_TIME    = 3'd1,
        CFG_TIMING_TOLERANCE = 3'd2,
        CFG_EXPECTED_ADDRESS = 3'd3,
        CFG_MISC_LAST_CODE   = 3'd4,
        CFG_PATH_CODE_FIRST  = 3'd5,
        CFG_PATH_CODE_LAST   = 3'd6,
        CFG_INVALID_NIBBLE   = 3'd7
    } cfg_index_t;

    localparam logic [15:0] HALF_BIT_TIME_RST    = 16'd889;
    localparam logic [15:0] FULL_BIT_TIME_RST    = 16'd1778;
    localparam logic [15:0] TIMING_TOLERANCE_RST = 16'd200;
    localparam logic [1:0]  EXPECTED_ADDRESS_RST = 2'd1;
    localparam logic [7:0]  MISC_LAST_CODE_RST   = 8'd7;
    localparam logic [7:0]  PATH_CODE_FIRST_RST  = 8'd16;
    localparam logic [7:0]  PATH_CODE_LAST_RST   = 8'd31;
    localparam logic [3:0]  INVALID_NIBBLE_RST   = 4'd8;

    localparam logic [1:0]  START_BITS = 2'b11;

    // true when len lies within tol of nom, lower bound clamped at zero
    function automatic logic near_nominal(
        input logic [15:0] len,
        input logic [15:0] nom,
        input logic [15:0] tol
    );
        logic [16:0] lo_sum;
        logic [16:0] hi_sum;
        lo_sum = {1'b0, len} + {1'b0, tol};
        hi_sum = {1'b0, nom} + {1'b0, tol};
        return (lo_sum >= {1'b0, nom}) && ({1'b0, len} <= hi_sum);
    endfunction

endpackage

/* sv/manchester_ir_frame_decoder_unit.sv */
// Manchester IR frame decoder: pulse classing, bit assembly and frame check.
// Path: input register, then result register; an item waits in the input register while a result stalls.
// Throughput: one item per cycle while out_ready holds; the decoder state updates as an item moves to the result.
// The result register parts the sides, so a new item fills an empty input register while a result waits.
// Reset: asynchronous, active low; config registers return to defaults, valid flags clear and the decoder clears.
module manchester_ir_frame_decoder_unit
    import mird_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic        pulse_level,
    input  logic [15:0] pulse_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        frame_toggle,
    output logic        frame_kind,
    output logic [7:0]  frame_payload,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration
    logic [15:0] half_bit_time_reg;
    logic [15:0] full_bit_time_reg;
    logic [15:0] timing_tolerance_reg;
    logic [1:0]  expected_address_reg;
    logic [7:0]  misc_last_code_reg;
    logic [7:0]  path_code_first_reg;
    logic [7:0]  path_code_last_reg;
    logic [3:0]  invalid_nibble_reg;

    // input register
    logic        in_valid_reg;
    logic        action_reg;
    logic        level_reg;
    logic [15:0] length_reg;

    // decoder state
    logic [3:0]  bit_count_reg,        bit_count_next;
    logic        half_phase_reg,       half_phase_next;
    logic        first_half_level_reg, first_half_level_next;
    logic [13:0] bit_shift_reg,        bit_shift_next;
    logic        held_toggle_reg,      held_toggle_next;
    logic        held_kind_reg,        held_kind_next;
    logic [7:0]  held_payload_reg,     held_payload_next;

    // result register
    logic        out_valid_reg;
    status_t     status_reg,           status_next;
    logic        toggle_reg;
    logic        kind_reg;
    logic [7:0]  payload_reg;

    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_time_reg    <= HALF_BIT_TIME_RST;
            full_bit_time_reg    <= FULL_BIT_TIME_RST;
            timing_tolerance_reg <= TIMING_TOLERANCE_RST;
            expected_address_reg <= EXPECTED_ADDRESS_RST;
            misc_last_code_reg   <= MISC_LAST_CODE_RST;
            path_code_first_reg  <= PATH_CODE_FIRST_RST;
            path_code_last_reg   <= PATH_CODE_LAST_RST;
            invalid_nibble_reg   <= INVALID_NIBBLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HALF_BIT_TIME:    half_bit_time_reg    <= cfg_data;
                CFG_FULL_BIT_TIME:    full_bit_time_reg    <= cfg_data;
                CFG_TIMING_TOLERANCE: timing_tolerance_reg <= cfg_data;
                CFG_EXPECTED_ADDRESS: expected_address_reg <= cfg_data[1:0];
                CFG_MISC_LAST_CODE:   misc_last_code_reg   <= cfg_data[7:0];
                CFG_PATH_CODE_FIRST:  path_code_first_reg  <= cfg_data[7:0];
                CFG_PATH_CODE_LAST:   path_code_last_reg   <= cfg_data[7:0];
                CFG_INVALID_NIBBLE:   invalid_nibble_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            action_reg <= action;
            level_reg  <= pulse_level;
            length_reg <= pulse_length;
        end
    end

    // one pulse carries one or two half-bits, so at most two steps
    always_comb
    begin
        logic is_half;
        logic is_full;
        logic run;
        logic [3:0]  cnt;
        logic        hp;
        logic        fhl;
        logic [13:0] sh;
        logic [7:0]  data;
        logic        frame_good;
        logic        misc_good;
        logic        move_good;

        is_half = near_nominal(length_reg, half_bit_time_reg, timing_tolerance_reg);
        is_full = near_nominal(length_reg, full_bit_time_reg, timing_tolerance_reg);
        cnt = bit_count_reg;
        hp  = half_phase_reg;
        fhl = first_half_level_reg;
        sh  = bit_shift_reg;
        run = 1'b1;
        data = 8'd0;
        misc_good = 1'b0;
        move_good = 1'b0;
        frame_good = 1'b0;

        held_toggle_next  = held_toggle_reg;
        held_kind_next    = held_kind_reg;
        held_payload_next = held_payload_reg;
        status_next       = ST_BUSY;

        if (action_reg)
        begin
            cnt = 4'd0;
            hp  = 1'b0;
            fhl = 1'b0;
            sh  = 14'd0;
            held_toggle_next  = 1'b0;
            held_kind_next    = 1'b0;
            held_payload_next = 8'd0;
        end
        else if (cnt >= FRAME_BITS)
        begin
            status_next = ST_ERROR;
        end
        else if (!is_half && !is_full)
        begin
            status_next = ST_ERROR;
        end
        else
        begin
            for (int i = 0; i < 2; i++)
            begin
                if (run && (i == 0 || !is_half))
                begin
                    if (!hp)
                    begin
                        fhl = level_reg;
                        hp  = 1'b1;
                    end
                    else if (fhl == level_reg)
                    begin
                        status_next = ST_ERROR;
                        run = 1'b0;
                    end
                    else
                    begin
                        // high then low decodes to 1, so the bit is the first level
                        sh  = {sh[12:0], fhl};
                        cnt = cnt + 4'd1;
                        hp  = 1'b0;
                        if (cnt == FRAME_BITS)
                        begin
                            run  = 1'b0;
                            data = sh[7:0];
                            misc_good = (data <= misc_last_code_reg) ||
                                        ((data >= path_code_first_reg) &&
                                         (data <= path_code_last_reg));
                            move_good = (data[3:0] != invalid_nibble_reg) &&
                                        (data[7:4] != invalid_nibble_reg);
                            frame_good = (sh[13:12] == START_BITS) &&
                                         (sh[10:9] == expected_address_reg) &&
                                         (sh[8] ? move_good : misc_good);
                            if (frame_good)
                            begin
                                status_next       = ST_DONE;
                                held_toggle_next  = sh[11];
                                held_kind_next    = sh[8];
                                held_payload_next = data;
                            end
                            else
                            begin
                                status_next = ST_ERROR;
                            end
                        end
                    end
                end
            end
        end

        bit_count_next        = cnt;
        half_phase_next       = hp;
        first_half_level_next = fhl;
        bit_shift_next        = sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg        <= 4'd0;
            half_phase_reg       <= 1'b0;
            first_half_level_reg <= 1'b0;
            bit_shift_reg        <= 14'd0;
            held_toggle_reg      <= 1'b0;
            held_kind_reg        <= 1'b0;
            held_payload_reg     <= 8'd0;
        end
        else if (advance)
        begin
            bit_count_reg        <= bit_count_next;
            half_phase_reg       <= half_phase_next;
            first_half_level_reg <= first_half_level_next;
            bit_shift_reg        <= bit_shift_next;
            held_toggle_reg      <= held_toggle_next;
            held_kind_reg        <= held_kind_next;
            held_payload_reg     <= held_payload_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg  <= status_next;
            toggle_reg  <= held_toggle_next;
            kind_reg    <= held_kind_next;
            payload_reg <= held_payload_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign frame_toggle  = toggle_reg;
    assign frame_kind    = kind_reg;
    assign frame_payload = payload_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= FRAME_BITS)
        else $error("bit count past frame length");

    a_frame_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_count_reg == FRAME_BITS) && !(advance && action_reg)
        |=> bit_count_reg == FRAME_BITS)
        else $error("finished frame left without restart");

    a_no_half_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        half_phase_reg |-> bit_count_reg < FRAME_BITS)
        else $error("pending half-bit after full frame");

    a_done_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_DONE) |-> bit_count_reg == FRAME_BITS)
        else $error("done shown without a full frame");
`endif

endmodule
